### sv/slt_pkg.sv
package slt_pkg;

  localparam int DEFAULT_FRAC_BITS = 16;

  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_BIRTH_LOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BIRTH_HIGH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DEATH_LOW   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEATH_HIGH  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEEP_OUTER = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEEP_INNER = 3'd5;

  localparam logic [15:0] RST_BIRTH_LOW   = 16'd18219;
  localparam logic [15:0] RST_BIRTH_HIGH  = 16'd23921;
  localparam logic [15:0] RST_DEATH_LOW   = 16'd17498;
  localparam logic [15:0] RST_DEATH_HIGH  = 16'd29164;
  localparam logic [15:0] RST_STEEP_OUTER = 16'd36571;
  localparam logic [15:0] RST_STEEP_INNER = 16'd6966;

  // Logistic curve at 0, 0.5, ..., 8 in Q0.16.
  function automatic logic [15:0] sig_tab(input logic [4:0] i);
    case (i)
      5'd0:    return 16'd32768;
      5'd1:    return 16'd40793;
      5'd2:    return 16'd47911;
      5'd3:    return 16'd53580;
      5'd4:    return 16'd57724;
      5'd5:    return 16'd60565;
      5'd6:    return 16'd62428;
      5'd7:    return 16'd63615;
      5'd8:    return 16'd64357;
      5'd9:    return 16'd64816;
      5'd10:   return 16'd65097;
      5'd11:   return 16'd65269;
      5'd12:   return 16'd65374;
      5'd13:   return 16'd65438;
      5'd14:   return 16'd65476;
      5'd15:   return 16'd65500;
      default: return 16'd65514;
    endcase
  endfunction

endpackage

### sv/smooth_life_transition_core.sv
// SmoothLife transition core.
// The input channel (in_valid, in_ready) carries one item per cell: the inner
// filling and the outer filling, both Q0.16. The output channel (out_valid,
// out_ready) returns one item per cell, the new cell value in Q0.16, in order.
// Thresholds and steepness values sit in an APB register file; write them
// only while no item is in flight.
// The datapath is a ten stage pipeline; new_value is registered in its last
// stage. One item is taken every cycle while the receiver does not stall;
// the multipliers of the three sigmoid evaluations, the threshold blend and
// the final product each sit in a stage of their own.
// When the receiver stalls, the whole pipeline holds and in_ready drops in
// the same cycle; nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the default
// thresholds and steepness values.
module smooth_life_transition_core #(
  parameter int FRAC_BITS = slt_pkg::DEFAULT_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] inner_filling,
  input  logic [15:0] outer_filling,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] new_value
);
  import slt_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int SB = F + 7;
  localparam int UP = (F >= 16) ? F - 16 : 0;
  localparam int DN = (F < 16) ? 16 - F : 0;
  localparam logic [F:0]   ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F-1:0] HALF = {1'b1, {(F-1){1'b0}}};

  function automatic logic [F-1:0] q16_in(input logic [15:0] v);
    logic [39:0] w;
    w = (40'(v) << UP) >> DN;
    return w[F-1:0];
  endfunction

  function automatic logic sat_of(input logic [F+15:0] mag);
    return mag[F+15:SB] >= 9'd16;
  endfunction

  function automatic logic [F-1:0] tab_lo(input logic [F+15:0] mag);
    logic [8:0] idx;
    idx = mag[F+15:SB];
    return q16_in(sig_tab({1'b0, idx[3:0]}));
  endfunction

  function automatic logic [F-1:0] tab_prod(input logic [F+15:0] mag);
    logic [8:0]     idx;
    logic [F-1:0]   lo;
    logic [F-1:0]   hi;
    logic [F-1:0]   diff;
    logic [2*F+6:0] p;
    idx  = mag[F+15:SB];
    lo   = q16_in(sig_tab({1'b0, idx[3:0]}));
    hi   = q16_in(sig_tab({1'b0, idx[3:0]} + 5'd1));
    diff = hi - lo;
    p    = (2*F+7)'(diff) * (2*F+7)'(mag[SB-1:0]);
    return p[SB+F-1:SB];
  endfunction

  // Register file.
  logic [15:0] birth_low, birth_high, death_low, death_high;
  logic [15:0] steep_outer, steep_inner;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_low   <= RST_BIRTH_LOW;
      birth_high  <= RST_BIRTH_HIGH;
      death_low   <= RST_DEATH_LOW;
      death_high  <= RST_DEATH_HIGH;
      steep_outer <= RST_STEEP_OUTER;
      steep_inner <= RST_STEEP_INNER;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_BIRTH_LOW:   birth_low   <= pwdata[15:0];
        REG_BIRTH_HIGH:  birth_high  <= pwdata[15:0];
        REG_DEATH_LOW:   death_low   <= pwdata[15:0];
        REG_DEATH_HIGH:  death_high  <= pwdata[15:0];
        REG_STEEP_OUTER: steep_outer <= pwdata[15:0];
        REG_STEEP_INNER: steep_inner <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BIRTH_LOW:   prdata = {16'd0, birth_low};
      REG_BIRTH_HIGH:  prdata = {16'd0, birth_high};
      REG_DEATH_LOW:   prdata = {16'd0, death_low};
      REG_DEATH_HIGH:  prdata = {16'd0, death_high};
      REG_STEEP_OUTER: prdata = {16'd0, steep_outer};
      REG_STEEP_INNER: prdata = {16'd0, steep_inner};
      default:         prdata = 32'd0;
    endcase
  end

  // Pipeline.
  logic [9:0] v;
  logic       en;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = v[9];

  logic [F-1:0]   m0, n1, n2, n3, n4, n5;
  logic           a_neg, b_neg, b_sat;
  logic [F+15:0]  a_mag;
  logic [F-1:0]   b_lo, b_prod;
  logic [F:0]     alive, t_in;
  logic [2*F:0]   pl, ql, ph, qh;
  logic [F-1:0]   lo5, hi5;
  logic           s_neg [2];
  logic [F+15:0]  s_mag [2];
  logic           u_neg [2];
  logic           u_sat [2];
  logic [F-1:0]   u_lo [2];
  logic [F-1:0]   u_prod [2];
  logic [F:0]     s [2];
  logic [F:0]     t_out [2];
  logic [2*F+1:0] r_prod;
  logic [F+1:0]   r;
  logic [47:0]    r_wide;

  assign m0     = q16_in(inner_filling);
  assign t_in   = b_sat ? ONE : (F+1)'(b_lo) + (F+1)'(b_prod);
  assign r      = r_prod[2*F+1:F];
  assign r_wide = (48'(r) << DN) >> UP;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      t_out[i] = u_sat[i] ? ONE : (F+1)'(u_lo[i]) + (F+1)'(u_prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Alive sigmoid: distance from one half times the inner steepness.
      a_neg <= m0 < HALF;
      a_mag <= (F+16)'((m0 < HALF) ? HALF - m0 : m0 - HALF) * (F+16)'(steep_inner);
      n1    <= q16_in(outer_filling);

      b_neg  <= a_neg;
      b_sat  <= sat_of(a_mag);
      b_lo   <= tab_lo(a_mag);
      b_prod <= tab_prod(a_mag);
      n2     <= n1;

      alive <= b_neg ? ONE - t_in : t_in;
      n3    <= n2;

      pl <= (2*F+1)'(ONE - alive) * (2*F+1)'(q16_in(birth_low));
      ql <= (2*F+1)'(alive) * (2*F+1)'(q16_in(death_low));
      ph <= (2*F+1)'(ONE - alive) * (2*F+1)'(q16_in(birth_high));
      qh <= (2*F+1)'(alive) * (2*F+1)'(q16_in(death_high));
      n4 <= n3;

      lo5 <= F'(((2*F+2)'(pl) + (2*F+2)'(ql)) >> F);
      hi5 <= F'(((2*F+2)'(ph) + (2*F+2)'(qh)) >> F);
      n5  <= n4;

      // Lane 0 is the birth/survival onset, lane 1 the upper cutoff.
      s_neg[0] <= n5 < lo5;
      s_mag[0] <= (F+16)'((n5 < lo5) ? lo5 - n5 : n5 - lo5) * (F+16)'(steep_outer);
      s_neg[1] <= n5 < hi5;
      s_mag[1] <= (F+16)'((n5 < hi5) ? hi5 - n5 : n5 - hi5) * (F+16)'(steep_outer);

      for (int i = 0; i < 2; i++) begin
        u_neg[i]  <= s_neg[i];
        u_sat[i]  <= sat_of(s_mag[i]);
        u_lo[i]   <= tab_lo(s_mag[i]);
        u_prod[i] <= tab_prod(s_mag[i]);
        s[i]      <= u_neg[i] ? ONE - t_out[i] : t_out[i];
      end

      r_prod <= (2*F+2)'(s[0]) * (2*F+2)'(ONE - s[1]);

      // A full-scale result cannot be held in Q0.16 and clips.
      new_value <= (r_wide > 48'd65535) ? 16'hFFFF : r_wide[15:0];
    end
  end

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import slt_pkg::*;

  localparam int  STEP_BITS = 23;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_CYCLES = 16;
  localparam logic [63:0] ONE = 64'd65536;

  class cell_scoreboard;
    logic [15:0] regs [6];
    logic [15:0] expected_q [$];
    int errors;
    logic [15:0] curve [17];

    function new();
      curve = '{16'd32768, 16'd40793, 16'd47911, 16'd53580, 16'd57724, 16'd60565,
                16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
                16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514};
      regs = '{RST_BIRTH_LOW, RST_BIRTH_HIGH, RST_DEATH_LOW, RST_DEATH_HIGH,
               RST_STEEP_OUTER, RST_STEEP_INNER};
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [15:0] val);
      if (idx < 6) regs[idx] = val;
    endfunction

    // Piecewise linear logistic of k * (x - a), Q0.16 in, Q0.16 out.
    function logic [63:0] logistic(logic [63:0] x, logic [63:0] a, logic [63:0] k);
      logic neg;
      logic [63:0] dmag, mag, idx, frac, lo_v, hi_v, t;
      neg = x < a;
      dmag = neg ? a - x : x - a;
      mag = dmag * k;
      idx = mag >> STEP_BITS;
      frac = mag & ((64'd1 << STEP_BITS) - 1);
      if (idx >= 16) begin
        t = ONE;
      end else begin
        lo_v = curve[idx];
        hi_v = curve[idx + 1];
        t = lo_v + (((hi_v - lo_v) * frac) >> STEP_BITS);
      end
      return neg ? ONE - t : t;
    endfunction

    function logic [63:0] mix(logic [63:0] p, logic [63:0] q, logic [63:0] t);
      return ((ONE - t) * p + t * q) >> 16;
    endfunction

    function void note(logic [15:0] m, logic [15:0] n);
      logic [63:0] alive, lo_t, hi_t, s1, s2, r;
      alive = logistic(m, ONE >> 1, regs[REG_STEEP_INNER]);
      lo_t = mix(regs[REG_BIRTH_LOW], regs[REG_DEATH_LOW], alive);
      hi_t = mix(regs[REG_BIRTH_HIGH], regs[REG_DEATH_HIGH], alive);
      s1 = logistic(n, lo_t, regs[REG_STEEP_OUTER]);
      s2 = logistic(n, hi_t, regs[REG_STEEP_OUTER]);
      r = (s1 * (ONE - s2)) >> 16;
      if (r > 64'hFFFF) r = 64'hFFFF;
      expected_q.push_back(r[15:0]);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check(logic [15:0] got);
      logic [15:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("new_value %0d arrived with nothing expected", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) report($sformatf("new_value %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [15:0] inner_filling, outer_filling, new_value;

  cell_scoreboard cells;
  int sender_idle, receiver_idle, hold_off;
  int unsigned cycles;

  smooth_life_transition_core u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) cells.note(inner_filling, outer_filling);
    if (!rst && out_valid && out_ready) cells.check(new_value);
  end

  // Receiver: random stalls, plus long hold-offs requested by the stimulus.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off = hold_off - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle);
      end
    end
  end

  task send_cell(logic [15:0] m, logic [15:0] n);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    inner_filling <= m;
    outer_filling <= n;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cells.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(int idx, logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= {16'($urandom_range(65535)), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cells.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task set_all(logic [15:0] bl, logic [15:0] bh, logic [15:0] dl, logic [15:0] dh,
               logic [15:0] so, logic [15:0] si);
    write_reg(REG_BIRTH_LOW, bl);
    write_reg(REG_BIRTH_HIGH, bh);
    write_reg(REG_DEATH_LOW, dl);
    write_reg(REG_DEATH_HIGH, dh);
    write_reg(REG_STEEP_OUTER, so);
    write_reg(REG_STEEP_INNER, si);
  endtask

  // Mostly cells near the live band and the inner half point, some plain noise.
  task random_cells(int count);
    logic [15:0] m, n, centre;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: begin
          m = 16'($urandom_range(65535));
          n = 16'($urandom_range(65535));
        end
        1: begin
          m = 16'd32768 + 16'($urandom_range(4000)) - 16'd2000;
          n = 16'($urandom_range(65535));
        end
        default: begin
          m = 16'($urandom_range(65535));
          centre = cells.regs[$urandom_range(3)];
          n = centre + 16'($urandom_range(6000)) - 16'd3000;
        end
      endcase
      send_cell(m, n);
    end
  endtask

  initial begin
    cells = new();
    cycles = 0;
    hold_off = 0;
    sender_idle = 14;
    receiver_idle = 68;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    inner_filling = '0;
    outer_filling = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed cells under the reset thresholds.
    send_cell(16'd0, 16'd0);
    send_cell(16'hFFFF, 16'hFFFF);
    send_cell(16'd0, 16'hFFFF);
    send_cell(16'hFFFF, 16'd0);
    send_cell(16'd32768, 16'd18219);
    send_cell(16'd32768, 16'd32768);
    send_cell(16'hAAAA, 16'h5555);
    send_cell(16'h5555, 16'hAAAA);
    send_cell(16'd40000, 16'd20000);
    send_cell(16'd20000, 16'd25000);
    random_cells(220);
    wait_drained();

    // Zero steepness gives exactly one half on both curves; writes past the
    // last register must leave the thresholds alone.
    set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    write_reg(6, 16'hFFFF);
    write_reg(7, 16'h1234);
    send_cell(16'd0, 16'd0);
    send_cell(16'hFFFF, 16'hFFFF);
    hold_off = 300;
    random_cells(230);
    wait_drained();

    sender_idle = 68;
    receiver_idle = 14;
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cell(16'd0, 16'hFFFF);
    send_cell(16'hFFFF, 16'd0);
    random_cells(230);
    wait_drained();

    // Crossed thresholds: the low edge sits above the high edge.
    set_all(16'd40000, 16'd20000, 16'd45000, 16'd10000, 16'd2000, 16'd3000);
    send_cell(16'd32768, 16'd30000);
    random_cells(230);
    wait_drained();

    sender_idle = 0;
    receiver_idle = 0;
    set_all(16'($urandom_range(65535)), 16'($urandom_range(65535)),
            16'($urandom_range(65535)), 16'($urandom_range(65535)),
            16'($urandom_range(65535)), 16'($urandom_range(65535)));
    random_cells(230);
    wait_drained();

    set_all(RST_BIRTH_LOW, RST_BIRTH_HIGH, RST_DEATH_LOW, RST_DEATH_HIGH,
            16'd256, 16'd65535);
    random_cells(230);
    wait_drained();

    if (cells.errors == 0 && cells.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
